/* src/great_circle_distance_core_macros.svh */
// assertion helpers for the great circle distance core
`ifndef GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH

// same-cycle implication
`define GCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcd check failed");

// next-cycle implication
`define GCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcd check failed");

`endif

/* src/gcd_pkg.sv */
package gcd_pkg;

   // angle and distance scaling
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int DIST_FRAC_BITS = 8;
   // half-angle phase: d * 2^(32-F) / 720 = d * 2^(28-F) / 45
   localparam int HALF_SHIFT = 28 - ANGLE_FRAC_BITS;
   // latitude phase: a * 2^(32-F) / 360 = a * 2^(29-F) / 45
   localparam int COS_SHIFT = 29 - ANGLE_FRAC_BITS;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // divide by 45: floor(2^32/45), corrected by one compare
   localparam int DIV45 = 45;
   localparam logic [26:0] RECIP45 = 27'd95443717;
   // exact floor(v/45) for v < 2^19 as (v * FRAC45) >> 26
   localparam logic [20:0] FRAC45 = 21'd1491309;

   // series denominators split into shift and odd factor
   localparam int ITERS = 8;
   localparam logic [2:0] DEN_SHIFT [ITERS] = '{3'd4, 3'd1, 3'd2, 3'd1, 3'd3, 3'd1, 3'd2, 3'd1};
   localparam logic [6:0] DEN_ODD [ITERS] = '{7'd17, 7'd105, 7'd39, 7'd55, 7'd9, 7'd21, 7'd5, 7'd3};
   localparam logic [30:0] DEN_RECIP [ITERS] = '{
      31'd252645135, 31'd40904450, 31'd110127366, 31'd78090314,
      31'd477218588, 31'd204522252, 31'd858993459, 31'd1431655765};

   // register stages of one quarter-turn sine evaluation
   localparam int SIN_STAGES = 3 + 3 * ITERS;

   localparam logic [23:0] DIST_SCALE = 24'(40000 << DIST_FRAC_BITS);
   localparam logic [22:0] MAX_DIST = 23'(20000 << DIST_FRAC_BITS);

   // sideband of the arcsine search
   typedef struct packed {
      logic [30:0] y;
      logic [29:0] u;
      logic        full;
   } asin_side_type;

endpackage

/* src/great_circle_distance_core.sv */
// Haversine distance between two points given as latitude and longitude in
// signed degrees with 16 fraction bits; returns km with 8 fraction bits on a
// sphere of 40000 km circumference, saturating at 20000 km. Fully pipelined:
// one beat is accepted every cycle while the result side does not stall.
// Most of the pipeline depth lies in the arcsine, a 31-step bit search in which every
// step is a 27-stage polynomial sine unit plus one update stage; the
// 31-stage square root and the front-end phase and sine stages make up the
// rest. A stall on the result side freezes the whole pipe without loss.
`include "great_circle_distance_core_macros.svh"

module great_circle_distance_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance_km[22:0], zero pad
   output logic [23:0]  rsp_tdata
);
   import gcd_pkg::*;

   localparam int LN = 4;
   localparam int ASTEPS = 31;

   logic en;

   logic signed [23:0] lat_a;
   logic signed [24:0] lon_a;
   logic signed [23:0] lat_b;
   logic signed [24:0] lon_b;
   logic [24:0] dlat_s;
   logic [25:0] dlon_s;

   logic [25:0] d_in [LN];
   logic        p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff;
   logic [25:0] p1_d_ff [LN];
   logic [25:0] p2_d_ff [LN];
   logic [20:0] p2_q_ff [LN];
   logic [20:0] p3_q_ff [LN];
   logic [5:0]  p3_rem_ff [LN];
   logic [20:0] p4_q_ff [LN];
   logic [12:0] p4_t_ff [LN];
   logic [LN-1:0][30:0] p5_r_ff;
   logic [LN-1:0] neg_in;
   logic [1:0]  p5_neg_ff;

   logic                sq4_vld;
   logic [LN-1:0][30:0] sq4_sin;
   logic [1:0]          sq4_neg;

   logic        h1_vld_ff, h2_vld_ff, sum_vld_ff;
   logic [30:0] h1_g_ff, h1_sl_ff, h1_cc_ff;
   logic [1:0]  h1_neg_ff, h2_neg_ff;
   logic [30:0] h2_g_ff, h2_h_ff;
   logic [61:0] g_prod, sl_prod, cc_prod, h_prod;
   logic [31:0] sum_raw;
   logic [30:0] sum_in;
   logic [30:0] sum_ff;

   logic [30:0] sq_vld_ff;
   logic [30:0] sq_root_ff [31];
   logic [60:0] sq_rem_ff  [31];

   logic [ASTEPS-1:0] as_vld_ff;
   asin_side_type     as_side_ff [ASTEPS];

   logic [30:0] u_fin;
   logic [54:0] dist_prod;
   logic        rsp_vld_ff;
   logic [22:0] rsp_dist_ff;

   // pipeline advances unless a finished beat waits
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // unpack the request beat
   assign lat_a = req_tdata[23:0];
   assign lon_a = req_tdata[48:24];
   assign lat_b = req_tdata[72:49];
   assign lon_b = req_tdata[97:73];

   // absolute differences and absolute latitudes
   assign dlat_s = {lat_a[23], lat_a} - {lat_b[23], lat_b};
   assign dlon_s = {lon_a[24], lon_a} - {lon_b[24], lon_b};
   assign d_in[0] = 26'(dlat_s[24] ? 25'(-dlat_s) : dlat_s);
   assign d_in[1] = dlon_s[25] ? 26'(-dlon_s) : dlon_s;
   assign d_in[2] = {2'b00, (lat_a[23] ? 24'(-lat_a) : lat_a)};
   assign d_in[3] = {2'b00, (lat_b[23] ? 24'(-lat_b) : lat_b)};

   // front-end valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= req_tvalid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
      end
   end

   // angle to phase in 2^-32 turn, four lanes
   for (genvar l = 0; l < LN; l++) begin : g_phase
      localparam int SH = (l < 2) ? HALF_SHIFT : COS_SHIFT;
      logic [52:0] q_prod;
      logic [25:0] rem_raw;
      logic [39:0] t_prod;
      logic [31:0] phase;
      logic [1:0]  quad;

      always_ff @(posedge clock) begin
         if (en) begin
            p1_d_ff[l] <= d_in[l];
         end
      end

      // quotient estimate by 45
      assign q_prod = 53'(p1_d_ff[l]) * 53'(RECIP45);
      always_ff @(posedge clock) begin
         if (en) begin
            p2_d_ff[l] <= p1_d_ff[l];
            p2_q_ff[l] <= q_prod[52:32];
         end
      end

      // one correction step
      assign rem_raw = p2_d_ff[l] - 26'(26'(p2_q_ff[l]) * 26'(DIV45));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_raw >= 26'(DIV45)) begin
               p3_q_ff[l]   <= p2_q_ff[l] + 21'd1;
               p3_rem_ff[l] <= 6'(rem_raw - 26'(DIV45));
            end else begin
               p3_q_ff[l]   <= p2_q_ff[l];
               p3_rem_ff[l] <= 6'(rem_raw);
            end
         end
      end

      // fraction bits of the phase from the remainder
      assign t_prod = (40'(p3_rem_ff[l]) << SH) * 40'(FRAC45);
      always_ff @(posedge clock) begin
         if (en) begin
            p4_q_ff[l] <= p3_q_ff[l];
            p4_t_ff[l] <= t_prod[38:26];
         end
      end

      // quadrant fold, cosine lanes advance a quarter turn
      assign phase = (32'(p4_q_ff[l]) << SH) | 32'(p4_t_ff[l]);
      assign quad  = phase[31:30] + ((l >= 2) ? 2'd1 : 2'd0);
      assign neg_in[l] = quad[1];
      always_ff @(posedge clock) begin
         if (en) begin
            p5_r_ff[l] <= quad[0] ? ONE_Q30 - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p5_neg_ff <= neg_in[3:2];
      end
   end

   // sines of both half differences and cosines of both latitudes
   gcd_sinq #(
      .LANES  (LN),
      .SIDE_W (2)
   ) u_sin_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p5_vld_ff),
      .in_r      (p5_r_ff),
      .in_side   (p5_neg_ff),
      .out_valid (sq4_vld),
      .out_sin   (sq4_sin),
      .out_side  (sq4_neg)
   );

   // squares and cosine product
   assign g_prod  = 62'(sq4_sin[0]) * 62'(sq4_sin[0]);
   assign sl_prod = 62'(sq4_sin[1]) * 62'(sq4_sin[1]);
   assign cc_prod = 62'(sq4_sin[2]) * 62'(sq4_sin[3]);
   assign h_prod  = 62'(h1_cc_ff) * 62'(h1_sl_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         h1_g_ff   <= g_prod[60:30];
         h1_sl_ff  <= sl_prod[60:30];
         h1_cc_ff  <= cc_prod[60:30];
         h1_neg_ff <= sq4_neg;
         h2_g_ff   <= h1_g_ff;
         h2_h_ff   <= h_prod[60:30];
         h2_neg_ff <= h1_neg_ff;
         sum_ff    <= sum_in;
      end
   end

   // signed sum of the haversine terms, clamped to [0, 1]
   always_comb begin
      if (h2_neg_ff[0] != h2_neg_ff[1]) begin
         sum_raw = (h2_g_ff > h2_h_ff) ? 32'(h2_g_ff - h2_h_ff) : 32'd0;
      end else begin
         sum_raw = 32'(h2_g_ff) + 32'(h2_h_ff);
      end
      sum_in = (sum_raw > 32'(ONE_Q30)) ? ONE_Q30 : sum_raw[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_vld_ff  <= 1'b0;
         h2_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else if (en) begin
         h1_vld_ff  <= sq4_vld;
         h2_vld_ff  <= h1_vld_ff;
         sum_vld_ff <= h2_vld_ff;
      end
   end

   // square root, one result bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= '0;
      end else if (en) begin
         sq_vld_ff <= {sq_vld_ff[29:0], sum_vld_ff};
      end
   end

   for (genvar i = 0; i < 31; i++) begin : g_sqrt
      localparam int B = 30 - i;
      logic [30:0] root_prev;
      logic [60:0] rem_prev;
      logic [61:0] trial;

      if (i == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = {sum_ff, 30'd0};
      end else begin : g_next
         assign root_prev = sq_root_ff[i-1];
         assign rem_prev  = sq_rem_ff[i-1];
      end

      assign trial = (62'(root_prev) << (B + 1)) | (62'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (en) begin
            if (62'(rem_prev) >= trial) begin
               sq_rem_ff[i]  <= 61'(62'(rem_prev) - trial);
               sq_root_ff[i] <= root_prev | (31'(1) << B);
            end else begin
               sq_rem_ff[i]  <= rem_prev;
               sq_root_ff[i] <= root_prev;
            end
         end
      end
   end

   // arcsine by bit search, one sine unit per step
   for (genvar j = 0; j < ASTEPS; j++) begin : g_asin
      logic          s_vld_in;
      asin_side_type s_side_in;
      logic [30:0]   s_r_in;
      logic          s_vld;
      logic [30:0]   s_sin;
      asin_side_type s_side;
      logic          fits;
      asin_side_type upd_in;

      if (j == 0) begin : g_first
         assign s_vld_in  = sq_vld_ff[30];
         assign s_side_in = '{y: sq_root_ff[30], u: 30'd0, full: 1'b0};
         assign s_r_in    = ONE_Q30;
      end else begin : g_next
         assign s_vld_in  = as_vld_ff[j-1];
         assign s_side_in = as_side_ff[j-1];
         assign s_r_in    = {1'b0, as_side_ff[j-1].u | (30'(1) << (30 - j))};
      end

      gcd_sinq #(
         .LANES  (1),
         .SIDE_W ($bits(asin_side_type))
      ) u_sin_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s_vld_in),
         .in_r      (s_r_in),
         .in_side   (s_side_in),
         .out_valid (s_vld),
         .out_sin   (s_sin),
         .out_side  (s_side)
      );

      assign fits = (s_sin <= s_side.y);

      // first step tests a full quarter turn, later steps set one bit
      always_comb begin
         upd_in = s_side;
         if (j == 0) begin
            upd_in.full = fits;
         end else if (!s_side.full && fits) begin
            upd_in.u = s_side.u | (30'(1) << (30 - j));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            as_side_ff[j] <= upd_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            as_vld_ff[j] <= 1'b0;
         end else if (en) begin
            as_vld_ff[j] <= s_vld;
         end
      end
   end

   // scale the angle to km with rounding
   assign u_fin = as_side_ff[ASTEPS-1].full ? ONE_Q30 : {1'b0, as_side_ff[ASTEPS-1].u};
   assign dist_prod = 55'(u_fin) * 55'(DIST_SCALE) + (55'(1) << 30);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= as_vld_ff[ASTEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_dist_ff <= dist_prod[53:31];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff};

   // checks
   `GCD_ASSERT_IMPLY(a_sum_clamped, clock, reset, sum_vld_ff, sum_ff <= ONE_Q30)
   `GCD_ASSERT_IMPLY(a_root_range, clock, reset, sq_vld_ff[30], sq_root_ff[30] <= ONE_Q30)
   `GCD_ASSERT_IMPLY(a_dist_range, clock, reset, rsp_vld_ff, rsp_dist_ff <= MAX_DIST)
   `GCD_ASSERT_NEXT(a_sum_to_sqrt, clock, reset, sum_vld_ff && en, sq_vld_ff[0])

endmodule

/* src/gcd_sinq.sv */
module gcd_sinq #(
   parameter int LANES = 1,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [LANES-1:0][30:0]  in_r,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic [LANES-1:0][30:0]  out_sin,
   output logic [SIDE_W-1:0]       out_side
);
   import gcd_pkg::*;

   localparam int NST = SIN_STAGES;

   logic [NST-1:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [NST];

   logic [30:0] x0_ff  [LANES];
   logic [30:0] x1_ff  [LANES];
   logic [31:0] x21_ff [LANES];
   logic [30:0] ax_ff  [LANES][ITERS];
   logic [31:0] ax2_ff [LANES][ITERS];
   logic [31:0] av_ff  [LANES][ITERS];
   logic [30:0] bx_ff  [LANES][ITERS];
   logic [31:0] bx2_ff [LANES][ITERS];
   logic [31:0] bv_ff  [LANES][ITERS];
   logic [31:0] bq_ff  [LANES][ITERS];
   logic [30:0] cx_ff  [LANES][ITERS];
   logic [31:0] cx2_ff [LANES][ITERS];
   logic [30:0] ct_ff  [LANES][ITERS];
   logic [30:0] sin_ff [LANES];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   // sideband shift line
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < NST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_side  = side_ff[NST-1];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [61:0] x_prod;
      logic [61:0] x2_prod;
      logic [61:0] s_prod;

      // quarter turn to radians
      assign x_prod = 62'(in_r[l]) * 62'(HALF_PI_Q30);
      always_ff @(posedge clock) begin
         if (en) begin
            x0_ff[l] <= x_prod[60:30];
         end
      end

      // x squared
      assign x2_prod = 62'(x0_ff[l]) * 62'(x0_ff[l]);
      always_ff @(posedge clock) begin
         if (en) begin
            x1_ff[l]  <= x0_ff[l];
            x21_ff[l] <= x2_prod[61:30];
         end
      end

      // nested series t = 1 - x2 t / den, one term per three stages
      for (genvar k = 0; k < ITERS; k++) begin : g_iter
         logic [30:0] px;
         logic [31:0] px2;
         logic [30:0] pt;
         logic [62:0] v_prod;
         logic [63:0] q_prod;
         logic [31:0] rem;
         logic [31:0] q_in;

         if (k == 0) begin : g_first
            assign px  = x1_ff[l];
            assign px2 = x21_ff[l];
            assign pt  = ONE_Q30;
         end else begin : g_next
            assign px  = cx_ff[l][k-1];
            assign px2 = cx2_ff[l][k-1];
            assign pt  = ct_ff[l][k-1];
         end

         // product and power-of-two part of the denominator
         assign v_prod = 63'(px2) * 63'(pt);
         always_ff @(posedge clock) begin
            if (en) begin
               ax_ff[l][k]  <= px;
               ax2_ff[l][k] <= px2;
               av_ff[l][k]  <= v_prod[61:30] >> DEN_SHIFT[k];
            end
         end

         // reciprocal estimate of the odd factor
         assign q_prod = 64'(av_ff[l][k]) * 64'(DEN_RECIP[k]);
         always_ff @(posedge clock) begin
            if (en) begin
               bx_ff[l][k]  <= ax_ff[l][k];
               bx2_ff[l][k] <= ax2_ff[l][k];
               bv_ff[l][k]  <= av_ff[l][k];
               bq_ff[l][k]  <= q_prod[63:32];
            end
         end

         // quotient correction and new term
         assign rem  = bv_ff[l][k] - 32'(bq_ff[l][k] * 32'(DEN_ODD[k]));
         assign q_in = (rem >= 32'(DEN_ODD[k])) ? bq_ff[l][k] + 32'd1 : bq_ff[l][k];
         always_ff @(posedge clock) begin
            if (en) begin
               cx_ff[l][k]  <= bx_ff[l][k];
               cx2_ff[l][k] <= bx2_ff[l][k];
               ct_ff[l][k]  <= 31'(32'(ONE_Q30) - q_in);
            end
         end
      end

      // sine and saturation at one
      assign s_prod = 62'(cx_ff[l][ITERS-1]) * 62'(ct_ff[l][ITERS-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            sin_ff[l] <= (s_prod[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : s_prod[60:30];
         end
      end

      assign out_sin[l] = sin_ff[l];
   end

endmodule

/* tb/great_circle_distance_core_test.sv */
`timescale 1ns / 100ps

module great_circle_distance_core_test;
   import gcd_pkg::*;

   localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
   localparam int PIPE_DEPTH = 935;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BEATS = 1500;
   localparam int DEG = 65536;

   // one directed row; the distance is typed in only where obvious
   typedef struct {
      logic signed [23:0] lat_a;
      logic signed [24:0] lon_a;
      logic signed [23:0] lat_b;
      logic signed [24:0] lon_b;
      bit                 known;
      logic [22:0]        distance;
   } route_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // distance_km[22:0], zero pad
   logic [23:0]  rsp_tdata;

   logic [22:0]  pending_distances [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;

   great_circle_distance_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // sine on a quarter turn, q30 in and out
   function automatic longint unsigned quarter_sine(longint unsigned r);
      longint unsigned x, x2, t;
      int dens [8];
      dens = '{272, 210, 156, 110, 72, 42, 20, 6};
      x = (r * longint'(HALF_PI_Q30)) >> 30;
      x2 = (x * x) >> 30;
      t = UNIT_Q30;
      for (int i = 0; i < 8; i++) begin
         t = UNIT_Q30 - ((x2 * t) >> 30) / longint'(dens[i]);
      end
      t = (x * t) >> 30;
      return (t > UNIT_Q30) ? UNIT_Q30 : t;
   endfunction

   // magnitude and sign of the sine of a full 32-bit phase
   function automatic longint unsigned phase_sine(logic [31:0] p, output bit neg);
      longint unsigned r;
      r = {34'd0, p[29:0]};
      if (p[30]) begin
         r = UNIT_Q30 - r;
      end
      neg = p[31];
      return quarter_sine(r);
   endfunction

   function automatic longint unsigned half_angle_sin_sq(longint unsigned d);
      logic [31:0] p;
      longint unsigned s;
      bit neg;
      p = 32'((d << (32 - ANGLE_FRAC_BITS)) / 720);
      s = phase_sine(p, neg);
      return (s * s) >> 30;
   endfunction

   function automatic longint unsigned latitude_cosine(longint lat, output bit neg);
      longint unsigned a;
      logic [31:0] p;
      a = (lat < 0) ? longint'(-lat) : longint'(lat);
      p = 32'((a << (32 - ANGLE_FRAC_BITS)) / 360);
      return phase_sine(p + 32'h4000_0000, neg);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // haversine distance in km * 256
   function automatic logic [22:0] haversine_km(logic signed [23:0] lat_a,
                                                logic signed [24:0] lon_a,
                                                logic signed [23:0] lat_b,
                                                logic signed [24:0] lon_b);
      longint la, lb, oa, ob;
      longint unsigned g, sl, ca, cb, h, total, y, u, c, km_q;
      bit na, nb;
      la = lat_a;
      lb = lat_b;
      oa = lon_a;
      ob = lon_b;
      g = half_angle_sin_sq((la >= lb) ? la - lb : lb - la);
      sl = half_angle_sin_sq((oa >= ob) ? oa - ob : ob - oa);
      ca = latitude_cosine(la, na);
      cb = latitude_cosine(lb, nb);
      h = (((ca * cb) >> 30) * sl) >> 30;
      // opposite cosine signs subtract, clamped at zero
      if (na != nb) begin
         total = (g > h) ? g - h : 0;
      end else begin
         total = g + h;
      end
      if (total > UNIT_Q30) total = UNIT_Q30;
      y = int_sqrt(total << 30);
      if (y > UNIT_Q30) y = UNIT_Q30;
      // arcsine by bit search
      if (quarter_sine(UNIT_Q30) <= y) begin
         u = UNIT_Q30;
      end else begin
         u = 0;
         for (int b = 29; b >= 0; b--) begin
            c = u | (64'd1 << b);
            if (quarter_sine(c) <= y) u = c;
         end
      end
      km_q = (((64'd40000 * u) << DIST_FRAC_BITS) + (64'd1 << 30)) >> 31;
      return km_q[22:0];
   endfunction

   task automatic report_mismatch(string what, logic [22:0] got, logic [22:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      mismatch_count++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls, in one of four modes picked at random
   logic [15:0] stall_pattern = 16'hb5c3;
   int          stall_mode = 0;
   always @(posedge clock) begin
      if (cycle_count % 128 == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_pattern <= 16'($urandom);
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_tready <= stall_pattern[0];
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   // result beat check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[22:0], '0);
         end else begin
            if (rsp_tdata[22:0] !== pending_distances[0]) begin
               report_mismatch("distance_km", rsp_tdata[22:0], pending_distances[0]);
            end
            void'(pending_distances.pop_front());
         end
      end
   end

   int burst_left = 0;

   // drive one beat, hold until accepted, then maybe leave a gap
   task automatic send_route(logic signed [23:0] lat_a, logic signed [24:0] lon_a,
                             logic signed [23:0] lat_b, logic signed [24:0] lon_b,
                             logic [22:0] distance);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, lon_b, lat_b, lon_a, lat_a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_distances.push_back(distance);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   function automatic logic signed [23:0] pick_lat();
      return 24'($signed($urandom_range(0, 2 * 90 * DEG)) - 90 * DEG);
   endfunction

   function automatic logic signed [24:0] pick_lon();
      return 25'($signed($urandom_range(0, 2 * 180 * DEG)) - 180 * DEG);
   endfunction

   route_row_type routes [] = '{
      // identical points
      '{24'sd0, 25'sd0, 24'sd0, 25'sd0, 1'b1, 23'd0},
      '{24'(90 * DEG), 25'(180 * DEG), 24'(90 * DEG), 25'(180 * DEG), 1'b1, 23'd0},
      '{-24'(90 * DEG), -25'(180 * DEG), -24'(90 * DEG), -25'(180 * DEG), 1'b1, 23'd0},
      // poles, antipodes and the date line
      '{24'(90 * DEG), 25'sd0, -24'(90 * DEG), 25'sd0, 1'b0, 23'd0},
      '{24'sd0, 25'sd0, 24'sd0, 25'(180 * DEG), 1'b0, 23'd0},
      '{24'sd0, -25'(180 * DEG), 24'sd0, 25'(180 * DEG), 1'b0, 23'd0},
      '{24'(90 * DEG), 25'sd0, -24'(90 * DEG), 25'(180 * DEG), 1'b0, 23'd0},
      '{24'(45 * DEG), 25'(90 * DEG), -24'(45 * DEG), -25'(90 * DEG), 1'b0, 23'd0},
      // one lsb apart
      '{24'sd0, 25'sd0, 24'sd1, 25'sd0, 1'b0, 23'd0},
      '{24'sd0, 25'sd0, 24'sd0, 25'sd1, 1'b0, 23'd0},
      // raw extremes beyond the legal range
      '{24'h7fffff, 25'h0ffffff, 24'h800000, 25'h1000000, 1'b0, 23'd0},
      '{24'h800000, 25'h1000000, 24'h7fffff, 25'h0ffffff, 1'b0, 23'd0},
      '{24'h7fffff, 25'h1000000, 24'h7fffff, 25'h0ffffff, 1'b0, 23'd0},
      '{24'hffffff, 25'h1ffffff, 24'h000000, 25'h0000000, 1'b0, 23'd0},
      // negative cosine, latitudes past the pole
      '{24'(120 * DEG), 25'sd0, 24'sd0, 25'(90 * DEG), 1'b0, 23'd0},
      '{24'(95 * DEG), 25'sd0, 24'(85 * DEG), 25'(180 * DEG), 1'b0, 23'd0},
      '{24'(120 * DEG), 25'sd0, 24'(60 * DEG), 25'(180 * DEG), 1'b0, 23'd0},
      '{-24'(100 * DEG), 25'(10 * DEG), 24'(100 * DEG), -25'(170 * DEG), 1'b0, 23'd0},
      // near saturation
      '{24'(1 * DEG), 25'sd0, -24'(1 * DEG), 25'(180 * DEG), 1'b0, 23'd0},
      '{24'sd0, 25'sd0, 24'sd0, 25'(179 * DEG), 1'b0, 23'd0}
   };

   initial begin
      logic signed [23:0] la, lb;
      logic signed [24:0] oa, ob;
      int kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (routes[i]) begin
         send_route(routes[i].lat_a, routes[i].lon_a, routes[i].lat_b, routes[i].lon_b,
                    routes[i].known ? routes[i].distance
                    : haversine_km(routes[i].lat_a, routes[i].lon_a,
                                   routes[i].lat_b, routes[i].lon_b));
      end

      // random routes
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         kind = $urandom_range(0, 9);
         la = pick_lat();
         oa = pick_lon();
         lb = pick_lat();
         ob = pick_lon();
         if (kind == 0) begin
            // raw bits, out of range included
            la = 24'($urandom);
            oa = 25'($urandom);
            lb = 24'($urandom);
            ob = 25'($urandom);
         end else if (kind == 1) begin
            // short hop
            lb = la + 24'($signed($urandom_range(0, 2000)) - 1000);
            ob = oa + 25'($signed($urandom_range(0, 2000)) - 1000);
         end else if (kind == 2) begin
            // near antipode
            lb = -la + 24'($signed($urandom_range(0, 4000)) - 2000);
            ob = oa + ((oa < 0) ? 25'(180 * DEG) : -25'(180 * DEG));
         end
         send_route(la, oa, lb, ob, haversine_km(la, oa, lb, ob));
      end
      req_tvalid <= 1'b0;

      while (pending_distances.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
